>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/hsu_pkg.sv
// Package with constants, types and helpers of the HyperLogLog sketch update block.
package hsu_pkg;

   localparam int PRECISION_BITS_DEF = 14;
   localparam int HASH_W             = 64;
   localparam int IDX_W              = 14;
   localparam int VALUE_W            = 6;
   localparam int CNT_W              = 7;

   localparam logic [63:0] FNV_BASIS       = 64'h14650fb0739d0383;
   // The FNV prime is 2^40 + 0x1b3.
   localparam int          FNV_PRIME_SHIFT = 40;
   localparam logic [63:0] FNV_PRIME_LOW   = 64'h1b3;
   localparam logic [63:0] MIX_MUL_A       = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL_B       = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT       = 33;

   localparam logic CMD_KEY_BYTE = 1'b0;
   localparam logic CMD_READ     = 1'b1;

   // Partial product selects of the shared 32x32 multiplier.
   localparam logic [1:0] MUL_LL = 2'd0;
   localparam logic [1:0] MUL_LH = 2'd1;
   localparam logic [1:0] MUL_HL = 2'd2;

   typedef struct packed {
      logic       clr_step;
      logic       capture;
      logic       xshift;
      logic       mul_en;
      logic [1:0] mul_step;
      logic       const_b;
      logic       acc_load;
      logic       acc_add;
      logic       x_from_acc;
      logic       lz_init;
      logic       lz_step;
      logic       mem_rd;
      logic       rd_sel_req;
      logic       upd;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic lz_done;
      logic rsp_free;
   } dp_sts_type;

   function automatic logic [3:0] lz8(input logic [7:0] b);
      logic [3:0] n;
      logic       found;
      n     = '0;
      found = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (!found) begin
            if (b[i]) begin
               found = 1'b1;
            end else begin
               n = n + 4'd1;
            end
         end
      end
      return n;
   endfunction

endpackage

>>> hw/rtl/hsu_datapath.sv
// Datapath: running hash, shared multiplier, leading-zero unit, register memory, result register.
module hsu_datapath #(
   parameter int PRECISION_BITS = hsu_pkg::PRECISION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hsu_pkg::dp_cmd_type          cmd,
   output hsu_pkg::dp_sts_type          sts,
   input  logic                         req_command,
   input  logic                         req_sketch_select,
   input  logic [7:0]                   req_key_byte,
   input  logic                         req_last_byte,
   input  logic [hsu_pkg::IDX_W-1:0]    req_read_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hsu_pkg::VALUE_W-1:0]  rsp_register_value,
   output logic [hsu_pkg::IDX_W-1:0]    rsp_register_index,
   output logic                         rsp_sketch_out
);

   localparam int AddrW    = PRECISION_BITS + 1;
   localparam int MemDepth = 2 ** AddrW;
   localparam int ExtW     = (PRECISION_BITS > hsu_pkg::IDX_W) ? PRECISION_BITS
                                                                : hsu_pkg::IDX_W;
   localparam int RankCap  = hsu_pkg::HASH_W - PRECISION_BITS;

   // Running hash and finalizer work value.
   logic [63:0] hash_ff, hash_in;
   logic [63:0] mix_v, hash_next;
   logic [63:0] x_ff, x_in;
   logic        sketch_ff, sketch_in;
   logic [PRECISION_BITS-1:0] idx_ff, idx_in;
   logic [ExtW-1:0] idx_ext;

   // Shared multiplier.
   logic [63:0] mul_const;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] acc_sum;

   // Leading-zero unit.
   logic [63:0] sh_ff, sh_in;
   logic [hsu_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic        lz_done_ff, lz_done_in;
   logic [PRECISION_BITS-1:0] slot_ff, slot_in;
   logic [7:0]  top_byte;
   logic [hsu_pkg::CNT_W-1:0] cnt_capped, rank7;
   logic [hsu_pkg::VALUE_W-1:0] rank6;

   // Register memory.
   logic [hsu_pkg::VALUE_W-1:0] mem [MemDepth];
   logic [hsu_pkg::VALUE_W-1:0] rd_data_ff;
   logic [AddrW-1:0] raddr, waddr;
   logic [hsu_pkg::VALUE_W-1:0] wdata;
   logic        mem_we;
   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;
   logic        clr_done_ff, clr_done_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [hsu_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [hsu_pkg::IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic        rsp_sketch_ff, rsp_sketch_in;

   assign mix_v     = hash_ff ^ 64'(req_key_byte);
   assign hash_next = (mix_v << hsu_pkg::FNV_PRIME_SHIFT) + (mix_v * hsu_pkg::FNV_PRIME_LOW);
   assign idx_ext   = ExtW'(req_read_index);

   always_comb begin
      hash_in   = hash_ff;
      sketch_in = sketch_ff;
      idx_in    = idx_ff;
      if (cmd.capture) begin
         sketch_in = req_sketch_select;
         idx_in    = idx_ext[PRECISION_BITS-1:0];
         if (req_command == hsu_pkg::CMD_KEY_BYTE) begin
            hash_in = req_last_byte ? hsu_pkg::FNV_BASIS : hash_next;
         end
      end
   end

   // Low 64 bits of a 64x64 product from three 32x32 partial products.
   assign mul_const = cmd.const_b ? hsu_pkg::MIX_MUL_B : hsu_pkg::MIX_MUL_A;

   always_comb begin
      case (cmd.mul_step)
         hsu_pkg::MUL_LL: begin
            mul_a = x_ff[31:0];
            mul_b = mul_const[31:0];
         end
         hsu_pkg::MUL_LH: begin
            mul_a = x_ff[31:0];
            mul_b = mul_const[63:32];
         end
         hsu_pkg::MUL_HL: begin
            mul_a = x_ff[63:32];
            mul_b = mul_const[31:0];
         end
         default: begin
            mul_a = x_ff[31:0];
            mul_b = mul_const[31:0];
         end
      endcase
   end

   assign prod_in = cmd.mul_en ? ({32'b0, mul_a} * {32'b0, mul_b}) : prod_ff;
   assign acc_sum = acc_ff + {prod_ff[31:0], 32'b0};

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_load) begin
         acc_in = prod_ff;
      end else if (cmd.acc_add) begin
         acc_in = acc_sum;
      end
   end

   always_comb begin
      x_in = x_ff;
      if (cmd.capture && req_command == hsu_pkg::CMD_KEY_BYTE && req_last_byte) begin
         x_in = hash_next;
      end else if (cmd.xshift) begin
         x_in = x_ff ^ (x_ff >> hsu_pkg::MIX_SHIFT);
      end else if (cmd.x_from_acc) begin
         x_in = acc_sum;
      end
   end

   // The rank field sits in the top bits after the slot is shifted out; one byte per step.
   assign top_byte = sh_ff[63:56];

   always_comb begin
      sh_in      = sh_ff;
      cnt_in     = cnt_ff;
      lz_done_in = lz_done_ff;
      slot_in    = slot_ff;
      if (cmd.lz_init) begin
         sh_in      = x_ff << PRECISION_BITS;
         cnt_in     = '0;
         lz_done_in = 1'b0;
         slot_in    = x_ff[63 -: PRECISION_BITS];
      end else if (cmd.lz_step && !lz_done_ff) begin
         if (top_byte != 8'd0) begin
            cnt_in     = cnt_ff + hsu_pkg::CNT_W'(hsu_pkg::lz8(top_byte));
            lz_done_in = 1'b1;
         end else begin
            sh_in  = sh_ff << 8;
            cnt_in = cnt_ff + hsu_pkg::CNT_W'(8);
            if (cnt_ff == hsu_pkg::CNT_W'(hsu_pkg::HASH_W - 8)) begin
               lz_done_in = 1'b1;
            end
         end
      end
   end

   assign cnt_capped = (cnt_ff >= hsu_pkg::CNT_W'(RankCap)) ? hsu_pkg::CNT_W'(RankCap) : cnt_ff;
   assign rank7      = cnt_capped + hsu_pkg::CNT_W'(1);
   assign rank6      = rank7[hsu_pkg::VALUE_W-1:0];

   // Clearing pass after reset, one entry per cycle.
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_done_in = clr_done_ff;
      if (cmd.clr_step && !clr_done_ff) begin
         clr_cnt_in = clr_cnt_ff + AddrW'(1);
         if (clr_cnt_ff == {AddrW{1'b1}}) begin
            clr_done_in = 1'b1;
         end
      end
   end

   always_comb begin
      raddr  = cmd.rd_sel_req ? {sketch_ff, idx_ff} : {sketch_ff, x_ff[63 -: PRECISION_BITS]};
      mem_we = 1'b0;
      waddr  = clr_cnt_ff;
      wdata  = '0;
      if (cmd.clr_step && !clr_done_ff) begin
         mem_we = 1'b1;
      end else if (cmd.upd && rank6 > rd_data_ff) begin
         mem_we = 1'b1;
         waddr  = {sketch_ff, slot_ff};
         wdata  = rank6;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[raddr];
      end
   end

   // The result register frees as soon as the held transaction is taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_sketch_in = rsp_sketch_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rd_data_ff;
         rsp_index_in  = hsu_pkg::IDX_W'(idx_ff);
         rsp_sketch_in = sketch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= hsu_pkg::FNV_BASIS;
         lz_done_ff   <= 1'b0;
         clr_cnt_ff   <= '0;
         clr_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         lz_done_ff   <= lz_done_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_done_ff  <= clr_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      sketch_ff     <= sketch_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      sh_ff         <= sh_in;
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_sketch_ff <= rsp_sketch_in;
   end

   assign sts.clr_done = clr_done_ff;
   assign sts.lz_done  = lz_done_ff;
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_register_value = rsp_value_ff;
   assign rsp_register_index = rsp_index_ff;
   assign rsp_sketch_out     = rsp_sketch_ff;

endmodule

>>> hw/rtl/hsu_ctrl.sv
// Controller state machine that sequences the hash finalizer, rank search and register access.
module hsu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic                req_last_byte,
   input  hsu_pkg::dp_sts_type sts,
   output hsu_pkg::dp_cmd_type cmd
);

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_XS   = 4'd2;
   localparam logic [3:0] ST_M0   = 4'd3;
   localparam logic [3:0] ST_M1   = 4'd4;
   localparam logic [3:0] ST_M2   = 4'd5;
   localparam logic [3:0] ST_M3   = 4'd6;
   localparam logic [3:0] ST_LZI  = 4'd7;
   localparam logic [3:0] ST_LZ   = 4'd8;
   localparam logic [3:0] ST_UPD  = 4'd9;
   localparam logic [3:0] ST_RD   = 4'd10;
   localparam logic [3:0] ST_RSP  = 4'd11;

   // Finalizer phase: first multiply, second multiply, final xor-shift.
   localparam logic [1:0] PH_A   = 2'd0;
   localparam logic [1:0] PH_B   = 2'd1;
   localparam logic [1:0] PH_OUT = 2'd2;

   logic [3:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.const_b = (phase_ff == PH_B);
      case (state_ff)
         ST_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               if (req_command == hsu_pkg::CMD_READ) begin
                  state_in = ST_RD;
               end else if (req_last_byte) begin
                  state_in = ST_XS;
                  phase_in = PH_A;
               end
            end
         end
         ST_XS: begin
            cmd.xshift = 1'b1;
            state_in   = (phase_ff == PH_OUT) ? ST_LZI : ST_M0;
         end
         ST_M0: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_step = hsu_pkg::MUL_LL;
            state_in     = ST_M1;
         end
         ST_M1: begin
            cmd.acc_load = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_step = hsu_pkg::MUL_LH;
            state_in     = ST_M2;
         end
         ST_M2: begin
            cmd.acc_add  = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_step = hsu_pkg::MUL_HL;
            state_in     = ST_M3;
         end
         ST_M3: begin
            cmd.x_from_acc = 1'b1;
            phase_in       = phase_ff + 2'd1;
            state_in       = ST_XS;
         end
         ST_LZI: begin
            cmd.lz_init = 1'b1;
            cmd.mem_rd  = 1'b1;
            state_in    = ST_LZ;
         end
         ST_LZ: begin
            if (sts.lz_done) begin
               state_in = ST_UPD;
            end else begin
               cmd.lz_step = 1'b1;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RD: begin
            cmd.mem_rd     = 1'b1;
            cmd.rd_sel_req = 1'b1;
            state_in       = ST_RSP;
         end
         ST_RSP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         phase_ff <= PH_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

>>> hw/rtl/hyperloglog_sketch_update.sv
// Top level of the HyperLogLog sketch update block: controller plus datapath.
// A key byte that is not the last leaves the block idle; the next transaction is accepted right after.
// A last byte keeps the block busy for two 64-bit multiplies on one shared
// 32x32 multiplier and a leading-zero search of 8 bits per cycle.
// A read result passes through the memory read register into the result register, later while a held result is stalled.
// After reset a clearing pass zeroes the sketches; the input is stalled until it is done.
module hyperloglog_sketch_update #(
   parameter int PRECISION_BITS = hsu_pkg::PRECISION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic                         req_sketch_select,
   input  logic [7:0]                   req_key_byte,
   input  logic                         req_last_byte,
   input  logic [hsu_pkg::IDX_W-1:0]    req_read_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hsu_pkg::VALUE_W-1:0]  rsp_register_value,
   output logic [hsu_pkg::IDX_W-1:0]    rsp_register_index,
   output logic                         rsp_sketch_out
);

   hsu_pkg::dp_cmd_type cmd;
   hsu_pkg::dp_sts_type sts;

   hsu_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_last_byte (req_last_byte),
      .sts           (sts),
      .cmd           (cmd)
   );

   hsu_datapath #(
      .PRECISION_BITS (PRECISION_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_command        (req_command),
      .req_sketch_select  (req_sketch_select),
      .req_key_byte       (req_key_byte),
      .req_last_byte      (req_last_byte),
      .req_read_index     (req_read_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_register_value (rsp_register_value),
      .rsp_register_index (rsp_register_index),
      .rsp_sketch_out     (rsp_sketch_out)
   );

endmodule

>>> hw/rtl/hsu_checker.sv
// Port-level checker for the HyperLogLog sketch update block, bound to the top level.
`include "assert_macros.svh"

module hsu_checker #(
   parameter int PRECISION_BITS = hsu_pkg::PRECISION_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_command,
   input logic                         req_last_byte,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [hsu_pkg::VALUE_W-1:0]  rsp_register_value,
   input logic [hsu_pkg::IDX_W-1:0]    rsp_register_index,
   input logic                         rsp_sketch_out
);

   localparam int MaxRank = hsu_pkg::HASH_W - PRECISION_BITS + 1;

   // A stalled result transaction holds its payload.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_register_value) && $stable(rsp_register_index) && $stable(rsp_sketch_out), "stalled result changed")

   // No stored rank can exceed the rank of an all-zero remainder.
   `ASSERT_IMPL(a_rank_range, clock, reset, rsp_valid, rsp_register_value <= hsu_pkg::VALUE_W'(MaxRank), "register value out of range")

   // The clearing pass keeps the input stalled right after reset.
   `ASSERT_IMPL(a_clear_stall, clock, reset, $past(reset) && !reset, req_stall, "input taken during clearing pass")

   // A key byte that is not the last leaves the input unstalled in the next cycle.
   `ASSERT_NEXT(a_byte_rate, clock, reset, req_valid && !req_stall && req_command == hsu_pkg::CMD_KEY_BYTE && !req_last_byte, !req_stall, "key byte stalled the input")

endmodule

bind hyperloglog_sketch_update hsu_checker #(
   .PRECISION_BITS (PRECISION_BITS)
) u_hsu_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_command        (req_command),
   .req_last_byte      (req_last_byte),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_register_value (rsp_register_value),
   .rsp_register_index (rsp_register_index),
   .rsp_sketch_out     (rsp_sketch_out)
);
